/* rtl/core/slc_pkg.sv */
// Shared types and constants for the sprite slot LRU tag store.
`default_nettype none

package slc_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TAG_W      = 16;
    localparam int TIME_W     = 32;
    localparam int OUT_IDX_W  = 4;

    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
    typedef logic [TAG_W-1:0]      tag_t;
    typedef logic [TIME_W-1:0]     stamp_t;
    typedef logic [OUT_IDX_W-1:0]  out_idx_t;

    localparam stamp_t TIME_MAX = '1;

    // Search record that walks down the cell row, one cell per cycle.
    typedef struct packed {
        logic      vld;
        logic      hit;
        slot_idx_t hit_idx;
        logic      free;
        slot_idx_t free_idx;
        stamp_t    best_time;
        slot_idx_t best_idx;
    } rec_t;

    // Broadcast write of the chosen slot.
    typedef struct packed {
        logic      en;
        slot_idx_t idx;
    } wr_t;

endpackage

`default_nettype wire

/* rtl/core/slc_cell.sv */
// One slot of the tag store plus its stage of the search record pipeline.
`default_nettype none

module slc_cell (
    input  wire              clk,
    input  wire              rst_n,
    input  slc_pkg::slot_idx_t cell_idx,
    input  slc_pkg::tag_t    req_id,
    input  slc_pkg::stamp_t  req_time,
    input  slc_pkg::rec_t    rec_in,
    output slc_pkg::rec_t    rec_out,
    input  slc_pkg::wr_t     wr
);
    import slc_pkg::*;

    logic   valid_reg;
    tag_t   tag_reg;
    stamp_t time_reg;
    rec_t   rec_reg;
    rec_t   rec_next;

    always_comb
    begin
        rec_next = rec_in;
        // first valid tag match wins
        if (!rec_in.hit && valid_reg && (tag_reg == req_id))
        begin
            rec_next.hit     = 1'b1;
            rec_next.hit_idx = cell_idx;
        end
        // lowest empty slot
        if (!rec_in.free && !valid_reg)
        begin
            rec_next.free     = 1'b1;
            rec_next.free_idx = cell_idx;
        end
        // strictly older only, so ties keep the lower index
        if (time_reg < rec_in.best_time)
        begin
            rec_next.best_time = time_reg;
            rec_next.best_idx  = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tag_reg   <= '0;
            time_reg  <= '0;
            rec_reg   <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
            if (wr.en && (wr.idx == cell_idx))
            begin
                valid_reg <= 1'b1;
                tag_reg   <= req_id;
                time_reg  <= req_time;
            end
        end
    end

    assign rec_out = rec_reg;

endmodule

`default_nettype wire

/* rtl/core/sprite_slot_lru_cache_top.sv */
// Top level of the sprite slot LRU tag store: request control and cell row.
//
// Fully associative tag store of NUM_SLOTS sprite slots with LRU replacement
// by timestamp. A request (sprite_id, now_ms) is taken at a rising edge with
// start high and busy low. The answer appears as a one-cycle pulse on done,
// with slot_index and hit valid in that same cycle; there is no way to hold
// it off, so sample it then. busy stays high from the cycle after acceptance
// through the cycle before done, and a new request may be issued in the cycle
// done is high. The search record is launched from a launch register and
// steps through the row of slot cells one cell per cycle, and the result and
// slot update are registered together as it leaves the last cell. On a hit
// the matching slot's time is refreshed; on a miss the lowest empty slot is
// filled, else the slot with the strictly smallest time (lowest index on
// ties; times compare as plain unsigned with no wrap handling). All slots are
// empty after reset. slot_index carries the low 4 bits of the slot number.
`default_nettype none

module sprite_slot_lru_cache_top (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    input  slc_pkg::tag_t     sprite_id,
    input  slc_pkg::stamp_t   now_ms,
    output logic              done,
    output slc_pkg::out_idx_t slot_index,
    output logic              hit
);
    import slc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    state_t   state_reg;
    logic     launch_reg;
    tag_t     id_reg;
    stamp_t   now_reg;
    logic     done_reg;
    out_idx_t slot_index_reg;
    logic     hit_reg;

    rec_t      chain [NUM_SLOTS+1];
    rec_t      head;
    rec_t      tail;
    wr_t       wr;
    slot_idx_t pick;
    logic [SLOT_IDX_W+OUT_IDX_W-1:0] pick_ext;
    logic      accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Fresh record: nothing found yet, best time at the top of the range so
    // slot 0 always lands as the first candidate.
    always_comb
    begin
        head           = '0;
        head.vld       = launch_reg;
        head.best_time = TIME_MAX;
    end

    assign chain[0] = head;
    assign tail     = chain[NUM_SLOTS];

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_cell
            slc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (slot_idx_t'(g)),
                .req_id   (id_reg),
                .req_time (now_reg),
                .rec_in   (chain[g]),
                .rec_out  (chain[g+1]),
                .wr       (wr)
            );
        end
    endgenerate

    // Hit beats empty slot beats oldest slot.
    always_comb
    begin
        if (tail.hit)
            pick = tail.hit_idx;
        else if (tail.free)
            pick = tail.free_idx;
        else
            pick = tail.best_idx;
    end

    assign pick_ext = {{OUT_IDX_W{1'b0}}, pick};

    // Commit lands in the same edge that registers the result.
    always_comb
    begin
        wr.en  = tail.vld && (state_reg == ST_SWEEP);
        wr.idx = pick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            launch_reg     <= 1'b0;
            done_reg       <= 1'b0;
            id_reg         <= '0;
            now_reg        <= '0;
            slot_index_reg <= '0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        id_reg     <= sprite_id;
                        now_reg    <= now_ms;
                        launch_reg <= 1'b1;
                        state_reg  <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    if (tail.vld)
                    begin
                        done_reg       <= 1'b1;
                        slot_index_reg <= pick_ext[OUT_IDX_W-1:0];
                        hit_reg        <= tail.hit;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign slot_index = slot_index_reg;
    assign hit        = hit_reg;

endmodule

`default_nettype wire
